### hw/rtl/online_longest_increasing_subsequence_top_macros.svh
// Assertion macros for the online longest increasing subsequence block.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ONLINE_LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH
`define ONLINE_LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define OLIS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define OLIS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/olis_pkg.sv
// Shared types and constants of the online longest increasing subsequence block.
// No dependencies; olis_if, olis_area, olis_ctrl and the top module use it.
package olis_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned DIM_W  = 16;
  localparam int unsigned AREA_W = 32;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRI    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

  // Predecessor code for the first member of a run.
  localparam logic [CNT_W-1:0] NO_PRED = 7'd64;

  typedef struct packed {
    logic              func;
    logic [KIND_W-1:0] shape_kind;
    logic [DIM_W-1:0]  first_dim;
    logic [DIM_W-1:0]  second_dim;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]  run_length;
    logic [IDX_W-1:0]  member_index;
    logic [KIND_W-1:0] member_kind;
    logic [DIM_W-1:0]  member_first_dim;
    logic [DIM_W-1:0]  member_second_dim;
    logic [AREA_W-1:0] member_area;
    logic              last_of_run;
    logic              sequence_empty;
    logic              store_full;
  } out_t;

  // One stored shape item with its link to the previous run member.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DIM_W-1:0]  first;
    logic [DIM_W-1:0]  second;
    logic [AREA_W-1:0] area;
    logic [CNT_W-1:0]  pred;
  } item_t;

  // A tail entry keeps a copy of its item's area so the search needs one read a step.
  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [IDX_W-1:0]  idx;
  } tail_t;

endpackage

### hw/rtl/olis_if.sv
// Valid/ready channel interfaces for input and result transactions.
// Depends on olis_pkg for the payload types.
interface olis_in_if;
  logic            valid;
  logic            ready;
  olis_pkg::in_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface olis_out_if;
  logic            valid;
  logic            ready;
  olis_pkg::out_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/olis_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module olis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/olis_area.sv
// Registered area unit: edge squared, length times breadth, or half of base times height.
// Depends on olis_pkg.
module olis_area (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [olis_pkg::KIND_W-1:0]         kind_i,
  input  logic [olis_pkg::DIM_W-1:0]          a_i,
  input  logic [olis_pkg::DIM_W-1:0]          b_i,
  output logic [olis_pkg::AREA_W-1:0]         area_o
);

  logic [olis_pkg::DIM_W-1:0]  b_op;
  logic [olis_pkg::AREA_W-1:0] prod;
  logic [olis_pkg::AREA_W-1:0] area_d;
  logic [olis_pkg::AREA_W-1:0] area_q;

  assign b_op   = (kind_i == olis_pkg::KIND_SQUARE) ? a_i : b_i;
  assign prod   = olis_pkg::AREA_W'(a_i) * olis_pkg::AREA_W'(b_op);
  assign area_d = (kind_i == olis_pkg::KIND_TRI) ? (prod >> 1) : prod;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      area_q <= area_d;
    end
  end

  assign area_o = area_q;

endmodule

### hw/rtl/olis_ctrl.sv
// Sequencer of the block: binary search over the tail RAM, commit of new items,
// predecessor walk and readout through the chain RAM. Depends on olis_pkg, olis_if.
`include "online_longest_increasing_subsequence_top_macros.svh"

module olis_ctrl #(
  parameter int unsigned MAX_ITEMS = olis_pkg::MAX_ITEMS_DEF,
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  olis_in_if.sink                       in_i,
  olis_out_if.source                    out_o,
  input  logic [olis_pkg::AREA_W-1:0]   area_i,
  output logic                          tail_we_o,
  output logic [AW-1:0]                 tail_waddr_o,
  output olis_pkg::tail_t               tail_wdata_o,
  output logic [AW-1:0]                 tail_raddr_o,
  input  olis_pkg::tail_t               tail_rdata_i,
  output logic                          item_we_o,
  output logic [AW-1:0]                 item_waddr_o,
  output olis_pkg::item_t               item_wdata_o,
  output logic [AW-1:0]                 item_raddr_o,
  input  olis_pkg::item_t               item_rdata_i,
  output logic                          chain_we_o,
  output logic [AW-1:0]                 chain_waddr_o,
  output logic [olis_pkg::IDX_W-1:0]    chain_wdata_o,
  output logic [AW-1:0]                 chain_raddr_o,
  input  logic [olis_pkg::IDX_W-1:0]    chain_rdata_i
);

  localparam int unsigned CW = olis_pkg::CNT_W;
  localparam int unsigned IW = olis_pkg::IDX_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SEARCH, S_COMMIT, S_RD_TAIL, S_WALK,
    S_EMIT_RD, S_EMIT_ITEM, S_EMIT_MEM, S_EMIT
  } state_e;

  state_e                          state_q, state_d;
  logic [olis_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic [olis_pkg::DIM_W-1:0]      first_q, first_d;
  logic [olis_pkg::DIM_W-1:0]      second_q, second_d;
  logic [CW-1:0]                   lo_q, lo_d;
  logic [CW-1:0]                   hi_q, hi_d;
  logic [CW-1:0]                   mid_q, mid_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [CW-1:0]                   tail_count_q, tail_count_d;
  logic [CW-1:0]                   item_count_q, item_count_d;
  logic [CW-1:0]                   len_q, len_d;
  logic [IW-1:0]                   k_q, k_d;
  logic [IW-1:0]                   m_q, m_d;
  olis_pkg::out_t                  res_q, res_d;
  logic                            out_vld_q, out_vld_d;
  olis_pkg::out_t                  out_q, out_d;

  logic                            out_free;
  logic [CW-1:0]                   lo_n, hi_n, mid_n, lo_m1, tc_m1, tc_new, len_p1, pred;
  logic [CW:0]                     mid_sum;
  logic [IW-1:0]                   cur, new_idx;

  assign out_free  = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    first_d      = first_q;
    second_d     = second_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    rd_vld_d     = rd_vld_q;
    tail_count_d = tail_count_q;
    item_count_d = item_count_q;
    len_d        = len_q;
    k_d          = k_q;
    m_d          = m_q;
    res_d        = res_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q && !out_o.ready;

    tail_we_o     = 1'b0;
    tail_waddr_o  = '0;
    tail_wdata_o  = '0;
    tail_raddr_o  = '0;
    item_we_o     = 1'b0;
    item_waddr_o  = '0;
    item_wdata_o  = '0;
    item_raddr_o  = '0;
    chain_we_o    = 1'b0;
    chain_waddr_o = '0;
    chain_wdata_o = '0;
    chain_raddr_o = '0;

    lo_n    = lo_q;
    hi_n    = hi_q;
    mid_sum = '0;
    mid_n   = '0;
    lo_m1   = '0;
    tc_m1   = tail_count_q - CW'(1);
    tc_new  = tail_count_q;
    len_p1  = len_q + CW'(1);
    pred    = olis_pkg::NO_PRED;
    cur     = '0;
    new_idx = item_count_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d   = in_i.payload.shape_kind;
          first_d  = in_i.payload.first_dim;
          second_d = (in_i.payload.shape_kind == olis_pkg::KIND_SQUARE) ?
                     '0 : in_i.payload.second_dim;
          if (in_i.payload.func == olis_pkg::FUNC_ADD) begin
            state_d = S_DECIDE;
          end else if (tail_count_q == '0) begin
            res_d                = '0;
            res_d.last_of_run    = 1'b1;
            res_d.sequence_empty = 1'b1;
            state_d              = S_EMIT;
          end else begin
            tail_raddr_o = tc_m1[AW-1:0];
            len_d        = '0;
            state_d      = S_RD_TAIL;
          end
        end
      end

      S_DECIDE: begin
        if (kind_q == olis_pkg::KIND_BAD) begin
          res_d             = '0;
          res_d.run_length  = tail_count_q;
          res_d.last_of_run = 1'b1;
          state_d           = S_EMIT;
        end else if (item_count_q >= MAX_CNT) begin
          res_d                   = '0;
          res_d.run_length        = tail_count_q;
          res_d.member_kind       = kind_q;
          res_d.member_first_dim  = first_q;
          res_d.member_second_dim = second_q;
          res_d.member_area       = area_i;
          res_d.last_of_run       = 1'b1;
          res_d.store_full        = 1'b1;
          state_d                 = S_EMIT;
        end else begin
          lo_d     = '0;
          hi_d     = tail_count_q;
          rd_vld_d = 1'b0;
          state_d  = S_SEARCH;
        end
      end

      // One probe per cycle: the data of the previous probe narrows the
      // interval and the next probe address follows from it at once.
      S_SEARCH: begin
        if (rd_vld_q) begin
          if (tail_rdata_i.area < area_i) begin
            lo_n = mid_q + CW'(1);
          end else begin
            hi_n = mid_q;
          end
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_sum      = {1'b0, lo_n} + {1'b0, hi_n};
          mid_n        = mid_sum[CW:1];
          mid_d        = mid_n;
          tail_raddr_o = mid_n[AW-1:0];
          rd_vld_d     = 1'b1;
        end else begin
          // Fetch the tail just below the insertion slot for the predecessor link.
          lo_m1        = lo_n - CW'(1);
          tail_raddr_o = lo_m1[AW-1:0];
          rd_vld_d     = 1'b0;
          state_d      = S_COMMIT;
        end
      end

      S_COMMIT: begin
        pred   = (lo_q == '0) ? olis_pkg::NO_PRED : CW'(tail_rdata_i.idx);
        tc_new = (lo_q == tail_count_q) ? (tail_count_q + CW'(1)) : tail_count_q;
        tail_we_o         = 1'b1;
        tail_waddr_o      = lo_q[AW-1:0];
        tail_wdata_o.area = area_i;
        tail_wdata_o.idx  = new_idx;
        item_we_o           = 1'b1;
        item_waddr_o        = new_idx[AW-1:0];
        item_wdata_o.kind   = kind_q;
        item_wdata_o.first  = first_q;
        item_wdata_o.second = second_q;
        item_wdata_o.area   = area_i;
        item_wdata_o.pred   = pred;
        tail_count_d = tc_new;
        item_count_d = item_count_q + CW'(1);
        res_d                   = '0;
        res_d.run_length        = tc_new;
        res_d.member_index      = new_idx;
        res_d.member_kind       = kind_q;
        res_d.member_first_dim  = first_q;
        res_d.member_second_dim = second_q;
        res_d.member_area       = area_i;
        res_d.last_of_run       = 1'b1;
        state_d                 = S_EMIT;
      end

      S_RD_TAIL: begin
        cur           = tail_rdata_i.idx;
        chain_we_o    = 1'b1;
        chain_waddr_o = len_q[AW-1:0];
        chain_wdata_o = cur;
        item_raddr_o  = cur[AW-1:0];
        len_d         = len_p1;
        if (len_p1 == tail_count_q) begin
          k_d     = len_q[IW-1:0];
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_WALK;
        end
      end

      // Follow predecessor links back from the top tail, one item a cycle.
      S_WALK: begin
        if (item_rdata_i.pred == olis_pkg::NO_PRED) begin
          k_d     = len_q[IW-1:0] - IW'(1);
          state_d = S_EMIT_RD;
        end else begin
          cur           = item_rdata_i.pred[IW-1:0];
          chain_we_o    = 1'b1;
          chain_waddr_o = len_q[AW-1:0];
          chain_wdata_o = cur;
          item_raddr_o  = cur[AW-1:0];
          len_d         = len_p1;
          if (len_p1 == tail_count_q) begin
            k_d     = len_q[IW-1:0];
            state_d = S_EMIT_RD;
          end
        end
      end

      S_EMIT_RD: begin
        chain_raddr_o = k_q[AW-1:0];
        state_d       = S_EMIT_ITEM;
      end

      S_EMIT_ITEM: begin
        m_d          = chain_rdata_i;
        item_raddr_o = chain_rdata_i[AW-1:0];
        state_d      = S_EMIT_MEM;
      end

      S_EMIT_MEM: begin
        res_d                   = '0;
        res_d.run_length        = tail_count_q;
        res_d.member_index      = m_q;
        res_d.member_kind       = item_rdata_i.kind;
        res_d.member_first_dim  = item_rdata_i.first;
        res_d.member_second_dim = item_rdata_i.second;
        res_d.member_area       = item_rdata_i.area;
        res_d.last_of_run       = (k_q == '0);
        state_d                 = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          if (res_q.last_of_run) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q - IW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= '0;
      first_q      <= '0;
      second_q     <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      rd_vld_q     <= 1'b0;
      tail_count_q <= '0;
      item_count_q <= '0;
      len_q        <= '0;
      k_q          <= '0;
      m_q          <= '0;
      res_q        <= '0;
      out_vld_q    <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      first_q      <= first_d;
      second_q     <= second_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      mid_q        <= mid_d;
      rd_vld_q     <= rd_vld_d;
      tail_count_q <= tail_count_d;
      item_count_q <= item_count_d;
      len_q        <= len_d;
      k_q          <= k_d;
      m_q          <= m_d;
      res_q        <= res_d;
      out_vld_q    <= out_vld_d;
      out_q        <= out_d;
    end
  end

  `OLIS_ASSERT(a_tails_within_items, tail_count_q <= item_count_q, "more tails than items")
  `OLIS_ASSERT(a_items_within_store, item_count_q <= MAX_CNT, "item count beyond store")
  `OLIS_ASSERT_NEXT(a_busy, in_i.valid && in_i.ready, state_q != S_IDLE, "idle after accept")
  `OLIS_ASSERT_NEXT(a_tail_hold, state_q != S_COMMIT, $stable(tail_count_q), "tail count moved")

endmodule

### hw/rtl/online_longest_increasing_subsequence_top.sv
// Add: accept, decide, binary search over the single-read tail RAM at one probe per cycle,
// commit and emit; an ignored add goes from decide straight to emit.
// Readout: the tail read and predecessor walk fill the chain RAM, then each member passes
// through chain read, item read, result build and output register; empty goes straight to emit.
// One transaction in flight at a time.
// Reset clears the counters and handshake state; the RAMs are not cleared and need no pass.
module online_longest_increasing_subsequence_top #(
  parameter int unsigned MAX_ITEMS = olis_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  olis_in_if.sink     in_i,
  olis_out_if.source  out_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic [olis_pkg::AREA_W-1:0] area;
  logic                        tail_we, item_we, chain_we;
  logic [AW-1:0]               tail_waddr, tail_raddr;
  logic [AW-1:0]               item_waddr, item_raddr;
  logic [AW-1:0]               chain_waddr, chain_raddr;
  olis_pkg::tail_t             tail_wdata, tail_rdata;
  olis_pkg::item_t             item_wdata, item_rdata;
  logic [olis_pkg::IDX_W-1:0]  chain_wdata, chain_rdata;

  olis_area u_area (
    .clk_i  (clk_i),
    .en_i   (in_i.valid && in_i.ready),
    .kind_i (in_i.payload.shape_kind),
    .a_i    (in_i.payload.first_dim),
    .b_i    (in_i.payload.second_dim),
    .area_o (area)
  );

  olis_ram #(
    .WIDTH ($bits(olis_pkg::tail_t)),
    .DEPTH (MAX_ITEMS)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (tail_waddr),
    .wdata_i (tail_wdata),
    .raddr_i (tail_raddr),
    .rdata_o (tail_rdata)
  );

  olis_ram #(
    .WIDTH ($bits(olis_pkg::item_t)),
    .DEPTH (MAX_ITEMS)
  ) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (item_we),
    .waddr_i (item_waddr),
    .wdata_i (item_wdata),
    .raddr_i (item_raddr),
    .rdata_o (item_rdata)
  );

  olis_ram #(
    .WIDTH (olis_pkg::IDX_W),
    .DEPTH (MAX_ITEMS)
  ) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (chain_we),
    .waddr_i (chain_waddr),
    .wdata_i (chain_wdata),
    .raddr_i (chain_raddr),
    .rdata_o (chain_rdata)
  );

  olis_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .area_i        (area),
    .tail_we_o     (tail_we),
    .tail_waddr_o  (tail_waddr),
    .tail_wdata_o  (tail_wdata),
    .tail_raddr_o  (tail_raddr),
    .tail_rdata_i  (tail_rdata),
    .item_we_o     (item_we),
    .item_waddr_o  (item_waddr),
    .item_wdata_o  (item_wdata),
    .item_raddr_o  (item_raddr),
    .item_rdata_i  (item_rdata),
    .chain_we_o    (chain_we),
    .chain_waddr_o (chain_waddr),
    .chain_wdata_o (chain_wdata),
    .chain_raddr_o (chain_raddr),
    .chain_rdata_i (chain_rdata)
  );

endmodule
